>>> design/swm_pkg.sv
// Package for the sliding window median filter.
// Holds the field widths, default window depth and the cell link structs.
// No dependencies.
package swm_pkg;

    localparam int VALUE_W      = 32;
    localparam int WSIZE_W      = 7;
    localparam int WINDOW_MAX_D = 64;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Raw cell contents handed to the cell one place lower.
    typedef struct packed {
        value_t value;
        logic   valid;
        logic   gt;       // entry is empty or greater than the new sample
    } down_link_t;

    // Cell contents after the outgoing entry is dropped, handed one place up.
    typedef struct packed {
        value_t value;
        logic   valid;
        logic   gt;
    } up_link_t;

    // Broadcast control for every cell of the row.
    typedef struct packed {
        logic   shift;    // a sample beat is taken this cycle
        logic   clear;    // window size written: empty the row
        logic   full;     // window full: drop the oldest entry
        value_t sample;
        value_t oldest;
    } cell_ctl_t;

endpackage

>>> design/swm_cell.sv
// One cell of the sorted row: holds one entry and its valid bit.
// Depends on swm_pkg for the link structs.
module swm_cell #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_D,
    parameter int INDEX      = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swm_pkg::cell_ctl_t            ctl,
    input  logic [$clog2(WINDOW_MAX)-1:0] median_idx,
    input  swm_pkg::down_link_t           from_above,
    input  swm_pkg::up_link_t             from_below,
    output swm_pkg::down_link_t           to_below,
    output swm_pkg::up_link_t             to_above,
    output swm_pkg::value_t               tap
);

    localparam int IDX_W = $clog2(WINDOW_MAX);

    swm_pkg::value_t value_reg;
    swm_pkg::value_t value_next;
    logic            valid_reg;
    logic            valid_next;
    logic            gt_here;
    logic            drop;
    swm_pkg::up_link_t shifted;

    assign gt_here = !valid_reg || (value_reg > ctl.sample);
    // Entries at or above the outgoing value slide down one place.
    assign drop    = ctl.full && valid_reg && (value_reg >= ctl.oldest);

    always_comb
    begin
        shifted.value = drop ? from_above.value : value_reg;
        shifted.valid = drop ? from_above.valid : valid_reg;
        shifted.gt    = drop ? from_above.gt    : gt_here;
    end

    assign to_below = '{value: value_reg, valid: valid_reg, gt: gt_here};
    assign to_above = shifted;

    // Insert the sample where the row first exceeds it; shift the rest up.
    always_comb
    begin
        if (shifted.gt) begin
            if (from_below.gt) begin
                value_next = from_below.value;
                valid_next = from_below.valid;
            end
            else
            begin
                value_next = ctl.sample;
                valid_next = 1'b1;
            end
        end
        else
        begin
            value_next = shifted.value;
            valid_next = shifted.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear) begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift) begin
            value_reg <= value_next;
        end
    end

    assign tap = (median_idx == IDX_W'(INDEX)) ? value_reg : '0;

endmodule

>>> design/sliding_window_median.sv
// Top level of the sliding window median filter: ring, control and cell row.
// Depends on swm_pkg and swm_cell.
//
//  channel      direction  handshake                       payload
//  sample       in         sample_valid / sample_stall     sample (s32)
//  median       out        median_valid / median_stall     median (s32)
//  window_size  in         window_size_wr                  window_size (u7)
//
// Cycles: a sample beat updates the whole sorted row in the cycle it is
// taken; its median waits as pending until the output register loads it.
// With the output drained a beat can be taken every cycle; the row update
// and the ring read of the next outgoing sample both finish in the same cycle.
// Reset: window size 1, window empty, no clearing pass (valid bits per cell).
// Stalls: a median waiting on median_stall holds the next pending result,
// and sample_stall rises only while that result cannot move forward.
module sliding_window_median #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_D
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [swm_pkg::VALUE_W-1:0] sample,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    output logic signed [swm_pkg::VALUE_W-1:0] median,
    output logic                           median_valid,
    input  logic                           median_stall,
    input  logic                           window_size_wr,
    input  logic [swm_pkg::WSIZE_W-1:0]    window_size
);

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = (CNT_W > swm_pkg::WSIZE_W) ? CNT_W : swm_pkg::WSIZE_W;

    // Window control
    logic [CNT_W-1:0] ws_reg;
    logic [CNT_W-1:0] ws_next;
    logic [IDX_W-1:0] mid_reg;
    logic [CNT_W-1:0] ws_m1;
    logic [CMP_W-1:0] wr_ext;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] ptr_next;
    logic [CNT_W-1:0] ptr_inc;
    logic             full;
    logic             gives_result;

    // Handshake
    logic             accept;
    logic             pend_reg;
    logic             load_out;
    logic             out_valid_reg;
    swm_pkg::value_t  out_reg;

    // Arrival ring
    swm_pkg::value_t  ring_mem [WINDOW_MAX];
    swm_pkg::value_t  ring_q;
    swm_pkg::value_t  last_sample_reg;
    logic             bypass_reg;
    logic [IDX_W-1:0] wr_addr;

    // Cell row
    swm_pkg::cell_ctl_t  ctl;
    swm_pkg::down_link_t down_link [WINDOW_MAX+1];
    swm_pkg::up_link_t   up_link   [WINDOW_MAX+1];
    swm_pkg::value_t     taps      [WINDOW_MAX];
    swm_pkg::value_t     tap_or;
    logic [WINDOW_MAX-1:0] valid_bits;

    assign full         = (fill_reg == ws_reg);
    assign gives_result = full || ((fill_reg + CNT_W'(1)) == ws_reg);

    // Advance the output register with a pending result whenever it is empty or being drained.
    assign load_out     = pend_reg && (!out_valid_reg || !median_stall);
    assign sample_stall = pend_reg && !load_out;
    assign accept       = sample_valid && !sample_stall;

    assign median       = out_reg;
    assign median_valid = out_valid_reg;

    // Clamp the written window size into 1..WINDOW_MAX.
    always_comb
    begin
        wr_ext = CMP_W'(window_size);
        if (wr_ext == '0) begin
            ws_next = CNT_W'(1);
        end
        else if (wr_ext > CMP_W'(WINDOW_MAX)) begin
            ws_next = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            ws_next = wr_ext[CNT_W-1:0];
        end
        ws_m1 = ws_next - CNT_W'(1);
    end

    // Fill count and oldest-slot pointer.
    always_comb
    begin
        ptr_inc   = {1'b0, ptr_reg} + CNT_W'(1);
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        if (window_size_wr) begin
            fill_next = '0;
            ptr_next  = '0;
        end
        else if (accept) begin
            if (full) begin
                ptr_next = (ptr_inc >= ws_reg) ? '0 : ptr_inc[IDX_W-1:0];
            end
            else
            begin
                fill_next = fill_reg + CNT_W'(1);
                ptr_next  = '0;
            end
        end
    end

    assign wr_addr = full ? ptr_reg : fill_reg[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ws_reg        <= CNT_W'(1);
            mid_reg       <= '0;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            bypass_reg    <= 1'b0;
        end
        else
        begin
            if (window_size_wr) begin
                ws_reg  <= ws_next;
                mid_reg <= ws_m1[CNT_W-1:1];
            end
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
            if (accept) begin
                pend_reg <= gives_result;
            end
            else if (load_out) begin
                pend_reg <= 1'b0;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end
            else if (!median_stall) begin
                out_valid_reg <= 1'b0;
            end
            // Same slot written and read: take the sample just written.
            bypass_reg <= accept && (wr_addr == ptr_next);
        end
    end

    // Write the new beat into the ring; read the next outgoing sample ahead.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            ring_mem[wr_addr] <= sample;
            last_sample_reg   <= sample;
        end
        ring_q <= ring_mem[ptr_next];
    end

    always_ff @(posedge clk)
    begin
        if (load_out) begin
            out_reg <= tap_or;
        end
    end

    always_comb
    begin
        ctl.shift  = accept;
        ctl.clear  = window_size_wr;
        ctl.full   = full;
        ctl.sample = sample;
        ctl.oldest = bypass_reg ? last_sample_reg : ring_q;
    end

    // Ends of the row: nothing below cell 0, an empty slot above the top.
    assign up_link[0]            = '{value: '0, valid: 1'b0, gt: 1'b0};
    assign down_link[WINDOW_MAX] = '{value: '0, valid: 1'b0, gt: 1'b1};

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        swm_cell #(
            .WINDOW_MAX (WINDOW_MAX),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .median_idx (mid_reg),
            .from_above (down_link[i+1]),
            .from_below (up_link[i]),
            .to_below   (down_link[i]),
            .to_above   (up_link[i+1]),
            .tap        (taps[i])
        );
        assign valid_bits[i] = down_link[i].valid;
    end

    // Only the median cell drives its tap; combine by bitwise OR.
    always_comb
    begin
        logic [WINDOW_MAX-1:0] column;
        for (int b = 0; b < swm_pkg::VALUE_W; b++) begin
            for (int i = 0; i < WINDOW_MAX; i++) begin
                column[i] = taps[i][b];
            end
            tap_or[b] = |column;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= ws_reg && ws_reg != '0 && ws_reg <= CNT_W'(WINDOW_MAX))
        else $error("fill count beyond window size");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_bits) == int'(fill_reg))
        else $error("cell valid bits disagree with fill count");

    a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept && gives_result && !window_size_wr |=> pend_reg)
        else $error("result lost after full-window beat");

    a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(median_valid) |-> $past(pend_reg))
        else $error("median shown without a pending result");
`endif

endmodule
